// File: src/est_pkg.sv
// Shared constants, types and codes for the ELF segment table checker.
package est_pkg;

	localparam int MAX_SEGMENTS = 32;
	localparam int PAGE_SHIFT   = 12;
	localparam int ADDR_W       = 64;
	localparam int PN_W         = ADDR_W - PAGE_SHIFT;
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int CFG_IDX_W    = 3;
	localparam int LIMIT_W      = 16;

	localparam logic [ADDR_W-1:0] PG_MASK = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);

	// program header type words
	localparam logic [31:0] PT_NULL      = 32'd0;
	localparam logic [31:0] PT_LOAD      = 32'd1;
	localparam logic [31:0] PT_NOTE      = 32'd4;
	localparam logic [31:0] PT_PHDR      = 32'd6;
	localparam logic [31:0] PT_GNU_STACK = 32'h6474E551;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_UNSUPPORTED = 4'd1,
		ST_INVALID     = 4'd2,
		ST_WX          = 4'd3,
		ST_RANGE       = 4'd4,
		ST_PAGES       = 4'd5,
		ST_OVERLAP     = 4'd6,
		ST_ENTRY       = 4'd7,
		ST_FULL        = 4'd8
	} est_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_SIZE    = 3'd0,
		CFG_ENTRY_ADDRESS = 3'd1,
		CFG_USER_BASE     = 3'd2,
		CFG_USER_END      = 3'd3,
		CFG_PAGE_LIMIT    = 3'd4
	} est_cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK1,
		S_CHK2,
		S_CHK3,
		S_CHK4,
		S_CHK5,
		S_SCAN,
		S_DONE
	} est_state_t;

	typedef struct packed {
		logic [31:0]       seg_type;
		logic [31:0]       seg_flags;
		logic [ADDR_W-1:0] file_offset;
		logic [ADDR_W-1:0] virt_addr;
		logic [ADDR_W-1:0] file_bytes;
		logic [ADDR_W-1:0] mem_bytes;
		logic [ADDR_W-1:0] align_bytes;
		logic              last;
	} est_in_t;

	typedef struct packed {
		logic [3:0]         status;
		logic               final_res;
		logic [LIMIT_W-1:0] pages_used;
	} est_out_t;

	// overlap query walking down the cell chain
	typedef struct packed {
		logic            vld;
		logic            hit;
		logic [PN_W-1:0] sp;
		logic [PN_W-1:0] ep;
	} est_query_t;

endpackage

// File: src/est_cell.sv
// One range cell: stores a page range and tests the passing query for overlap.
module est_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  est_pkg::est_query_t    q_in,
	output est_pkg::est_query_t    q_out,
	input  logic                   occ,
	input  logic                   wr_en,
	input  logic [est_pkg::PN_W-1:0] wr_sp,
	input  logic [est_pkg::PN_W-1:0] wr_ep
);
	import est_pkg::*;

	logic [PN_W-1:0] start_q;
	logic [PN_W-1:0] end_q;
	logic            hit;

	assign hit = occ && (q_in.sp < end_q) && (start_q < q_in.ep);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_q <= wr_sp;
			end_q   <= wr_ep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_out <= '0;
		end else begin
			q_out.vld <= q_in.vld;
			q_out.hit <= q_in.vld && (q_in.hit || hit);
			q_out.sp  <= q_in.sp;
			q_out.ep  <= q_in.ep;
		end
	end

endmodule

// File: src/elf_segment_table_checker_unit.sv
// Top level of the ELF64 program header table checker.
//
// Usage:
//   Program headers enter on in_valid/in_stall/in_data, one request per header;
//   the header with last set closes the table. Each request yields exactly one
//   result on out_valid/out_stall/out_data: the sticky status so far, or on
//   the closing header the final verdict (ok, entry missing, or first error).
//   Registers are written on cfg_valid/cfg_ready/cfg_index/cfg_data; the user
//   must write them only while the block is idle, the block itself does not
//   enforce this. cfg_ready is always high, unknown indexes are ignored.
// Flow:
//   One header at a time. A fully checked load header runs S_CHK1 to S_CHK5,
//   its overlap query walks the cell chain in S_SCAN, and it commits in
//   S_DONE; the block returns to idle before the next header is taken.
//   Skipped, rejected or post-error headers leave early. The cell chain
//   length sets the rate while the output is not stalled.
// Reset:
//   arst_n clears the table state and registers (page_limit to 256);
//   stored page ranges are not cleared, only cells below the count are used.
// Stall:
//   A finished result waits in the output register; the block goes back to
//   idle and takes the next header, holding its result until the slot frees.
module elf_segment_table_checker_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  est_pkg::est_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output est_pkg::est_out_t               out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [est_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [est_pkg::ADDR_W-1:0]      cfg_data
);
	import est_pkg::*;

	// configuration
	logic [ADDR_W-1:0]  image_size_q;
	logic [ADDR_W-1:0]  entry_address_q;
	logic [ADDR_W-1:0]  user_base_q;
	logic [ADDR_W-1:0]  user_end_q;
	logic [LIMIT_W-1:0] page_limit_q;

	// table state
	logic [CNT_W-1:0]   count_q;
	logic [LIMIT_W-1:0] total_q;
	logic               seen_q;
	logic               entry_q;
	logic [3:0]         sticky_q;

	// working registers for the header in flight
	est_state_t         state_q, state_d;
	est_in_t            item_q;
	logic [3:0]         code_q;
	logic               commit_q;
	logic [ADDR_W:0]    fend_q;
	logic [ADDR_W:0]    mend_q;
	logic [ADDR_W:0]    mapped_q;
	logic               range_err_q;
	logic [PN_W-1:0]    sp_q;
	logic [PN_W-1:0]    ep_q;
	logic [PN_W-1:0]    pages_q;
	logic               entry_hit_q;

	logic               out_valid_q;
	est_out_t           out_q;

	// check terms
	logic               skip_type;
	logic               align_bad;
	logic               invalid;
	logic               wx;
	logic               chk2_err;
	logic               chk3_err;
	logic               chk5_err;
	logic [LIMIT_W-1:0] budget;
	logic               accept;
	logic               done_go;

	// commit values
	logic [CNT_W-1:0]   count_d;
	logic [LIMIT_W-1:0] total_d;
	logic               seen_d;
	logic               entry_d;
	logic [3:0]         fin_status;

	// cell chain
	est_query_t         chain [MAX_SEGMENTS+1];
	est_query_t         tail;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done_go   = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign tail      = chain[MAX_SEGMENTS];

	always_comb begin
		skip_type = (item_q.seg_type == PT_NULL) || (item_q.seg_type == PT_NOTE) ||
			(item_q.seg_type == PT_PHDR) || (item_q.seg_type == PT_GNU_STACK);
		// alignment: zero, or one bit at or below the page size
		align_bad = (item_q.align_bytes != '0) &&
			((item_q.align_bytes[ADDR_W-1:PAGE_SHIFT+1] != '0) ||
			((item_q.align_bytes[PAGE_SHIFT:0] &
			(item_q.align_bytes[PAGE_SHIFT:0] - 1'b1)) != '0));
		invalid = (item_q.seg_flags[31:3] != '0) ||
			(item_q.file_bytes > item_q.mem_bytes) || align_bad ||
			(item_q.virt_addr[PAGE_SHIFT-1:0] != item_q.file_offset[PAGE_SHIFT-1:0]);
		wx = (item_q.seg_flags[1:0] == 2'b11);
		chk2_err = fend_q[ADDR_W] || (fend_q[ADDR_W-1:0] > image_size_q);
		chk3_err = range_err_q || mend_q[ADDR_W] || (item_q.virt_addr < user_base_q) ||
			(mend_q[ADDR_W-1:0] > user_end_q) || (mend_q[ADDR_W-1:0] <= item_q.virt_addr);
		budget   = page_limit_q - total_q;
		chk5_err = (total_q > page_limit_q) ||
			(pages_q > {{(PN_W-LIMIT_W){1'b0}}, budget});
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = (sticky_q != ST_OK) ? S_DONE : S_CHK1;
			end
			S_CHK1: begin
				if (skip_type || item_q.seg_type != PT_LOAD || item_q.mem_bytes == '0 ||
					invalid || wx) state_d = S_DONE;
				else state_d = S_CHK2;
			end
			S_CHK2: state_d = chk2_err ? S_DONE : S_CHK3;
			S_CHK3: state_d = chk3_err ? S_DONE : S_CHK4;
			S_CHK4: state_d = mapped_q[ADDR_W] ? S_DONE : S_CHK5;
			S_CHK5: state_d = chk5_err ? S_DONE : S_SCAN;
			S_SCAN: begin
				if (tail.vld) state_d = S_DONE;
			end
			S_DONE: begin
				if (done_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// header datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q   <= in_data;
					code_q   <= sticky_q;
					commit_q <= 1'b0;
				end
			end
			S_CHK1: begin
				// empty load segments are skipped; other types are judged by type alone
				if (skip_type || (item_q.seg_type == PT_LOAD && item_q.mem_bytes == '0))
					code_q <= ST_OK;
				else if (item_q.seg_type != PT_LOAD) code_q <= ST_UNSUPPORTED;
				else if (invalid) code_q <= ST_INVALID;
				else if (wx) code_q <= ST_WX;
				fend_q <= {1'b0, item_q.file_offset} + {1'b0, item_q.file_bytes};
			end
			S_CHK2: begin
				if (chk2_err) code_q <= ST_RANGE;
				range_err_q <= chk2_err;
				mend_q <= {1'b0, item_q.virt_addr} + {1'b0, item_q.mem_bytes};
			end
			S_CHK3: begin
				if (chk3_err) code_q <= ST_RANGE;
				mapped_q <= {1'b0, mend_q[ADDR_W-1:0]} + {1'b0, PG_MASK};
			end
			S_CHK4: begin
				if (mapped_q[ADDR_W]) code_q <= ST_RANGE;
				sp_q    <= item_q.virt_addr[ADDR_W-1:PAGE_SHIFT];
				ep_q    <= mapped_q[ADDR_W-1:PAGE_SHIFT];
				pages_q <= mapped_q[ADDR_W-1:PAGE_SHIFT] - item_q.virt_addr[ADDR_W-1:PAGE_SHIFT];
				entry_hit_q <= item_q.seg_flags[0] && (entry_address_q >= item_q.virt_addr) &&
					(entry_address_q < mend_q[ADDR_W-1:0]);
			end
			S_CHK5: begin
				if (chk5_err) code_q <= ST_PAGES;
			end
			S_SCAN: begin
				if (tail.vld) begin
					if (tail.hit) code_q <= ST_OVERLAP;
					else if (count_q >= CNT_W'(MAX_SEGMENTS)) code_q <= ST_FULL;
					else commit_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// table update at the end of a header
	always_comb begin
		count_d = count_q;
		total_d = total_q;
		seen_d  = seen_q;
		entry_d = entry_q;
		if (commit_q) begin
			count_d = count_q + 1'b1;
			total_d = total_q + pages_q[LIMIT_W-1:0];
			seen_d  = 1'b1;
			entry_d = entry_q || entry_hit_q;
		end
		fin_status = code_q;
		if (item_q.last && code_q == ST_OK && !(seen_d && entry_d)) fin_status = ST_ENTRY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q    <= '0;
			entry_address_q <= '0;
			user_base_q     <= '0;
			user_end_q      <= '0;
			page_limit_q    <= LIMIT_W'(256);
			count_q         <= '0;
			total_q         <= '0;
			seen_q          <= 1'b0;
			entry_q         <= 1'b0;
			sticky_q        <= ST_OK;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_IMAGE_SIZE:    image_size_q    <= cfg_data;
					CFG_ENTRY_ADDRESS: entry_address_q <= cfg_data;
					CFG_USER_BASE:     user_base_q     <= cfg_data;
					CFG_USER_END:      user_end_q      <= cfg_data;
					CFG_PAGE_LIMIT:    page_limit_q    <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (done_go) begin
				out_valid_q <= 1'b1;
				if (item_q.last) begin
					count_q  <= '0;
					total_q  <= '0;
					seen_q   <= 1'b0;
					entry_q  <= 1'b0;
					sticky_q <= ST_OK;
				end else begin
					count_q  <= count_d;
					total_q  <= total_d;
					seen_q   <= seen_d;
					entry_q  <= entry_d;
					sticky_q <= code_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			out_q.status     <= fin_status;
			out_q.final_res  <= item_q.last;
			out_q.pages_used <= total_d;
		end
	end

	// overlap query enters the chain as the header leaves the page check
	assign chain[0].vld = (state_q == S_CHK5) && !chk5_err;
	assign chain[0].hit = 1'b0;
	assign chain[0].sp  = sp_q;
	assign chain[0].ep  = ep_q;

	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		est_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.q_in   (chain[i]),
			.q_out  (chain[i+1]),
			.occ    (CNT_W'(i) < count_q),
			.wr_en  (done_go && commit_q && (count_q == CNT_W'(i))),
			.wr_sp  (sp_q),
			.wr_ep  (ep_q)
		);
	end

	// a result is only loaded from the commit state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared outside commit");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SEGMENTS))
		else $error("range count beyond capacity");

	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> (state_q == S_SCAN))
		else $error("query left chain outside scan");

	a_commit_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(done_go && commit_q) |->
		({{(PN_W-LIMIT_W){1'b0}}, total_q} + pages_q <= {{(PN_W-LIMIT_W){1'b0}}, page_limit_q}))
		else $error("committed segment exceeds page budget");

endmodule
